>>> rtl/rmcd_pkg.sv
package rmcd_pkg;

  localparam int SpanWidth  = 16;
  localparam int CfgWidth   = 16;
  localparam int FrameWidth = 64;
  localparam int CardWidth  = 24;
  localparam int InDataWidth  = 24;
  localparam int OutDataWidth = 24;

  localparam logic [CfgWidth-1:0] ShortMinReset = 16'd96;
  localparam logic [CfgWidth-1:0] ShortMaxReset = 16'd224;
  localparam logic [CfgWidth-1:0] LongMinReset  = 16'd256;
  localparam logic [CfgWidth-1:0] LongMaxReset  = 16'd384;

  localparam logic [10:0] Preamble = 11'h3FE;
  localparam logic [5:0]  BadTagA  = 6'd26;
  localparam logic [5:0]  BadTagB  = 6'd32;

  typedef enum logic [1:0] {
    CFG_SHORT_MIN = 2'd0,
    CFG_SHORT_MAX = 2'd1,
    CFG_LONG_MIN  = 2'd2,
    CFG_LONG_MAX  = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    PHASE_START1 = 2'd0,
    PHASE_MID1   = 2'd1,
    PHASE_MID0   = 2'd2,
    PHASE_START0 = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_SHORT_LOW  = 2'd0,
    EV_SHORT_HIGH = 2'd1,
    EV_LONG_LOW   = 2'd2,
    EV_LONG_HIGH  = 2'd3
  } event_t;

  typedef enum logic {
    CMD_FEED    = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_t;

  typedef struct packed {
    logic   classed;
    event_t kind;
  } edge_class_t;

  typedef struct packed {
    logic valid;
    logic value;
  } bit_out_t;

  // standard manchester transition table
  function automatic phase_t phase_next(input phase_t cur, input event_t ev);
    phase_t nxt;
    nxt = PHASE_MID1;
    case (cur)
      PHASE_START1: begin
        case (ev)
          EV_SHORT_LOW: nxt = PHASE_MID1;
          default:      nxt = PHASE_START1;
        endcase
      end
      PHASE_MID1: begin
        case (ev)
          EV_SHORT_LOW:  nxt = PHASE_MID1;
          EV_SHORT_HIGH: nxt = PHASE_START1;
          EV_LONG_LOW:   nxt = PHASE_MID1;
          default:       nxt = PHASE_MID0;
        endcase
      end
      PHASE_MID0: begin
        case (ev)
          EV_SHORT_LOW:  nxt = PHASE_START0;
          EV_SHORT_HIGH: nxt = PHASE_MID0;
          EV_LONG_LOW:   nxt = PHASE_MID1;
          default:       nxt = PHASE_MID0;
        endcase
      end
      default: begin
        case (ev)
          EV_SHORT_HIGH: nxt = PHASE_MID0;
          default:       nxt = PHASE_START0;
        endcase
      end
    endcase
    return nxt;
  endfunction

endpackage

>>> rtl/rmcd_classify.sv
module rmcd_classify (
  input  logic                          level,
  input  logic [rmcd_pkg::SpanWidth-1:0] span_us,
  input  logic [rmcd_pkg::CfgWidth-1:0]  short_min,
  input  logic [rmcd_pkg::CfgWidth-1:0]  short_max,
  input  logic [rmcd_pkg::CfgWidth-1:0]  long_min,
  input  logic [rmcd_pkg::CfgWidth-1:0]  long_max,
  output rmcd_pkg::edge_class_t          edge_class
);

  logic is_short;
  logic is_long;

  assign is_short = (span_us > short_min) && (span_us < short_max);
  assign is_long  = (span_us > long_min) && (span_us < long_max);

  // short window wins where the two overlap
  always_comb begin
    edge_class.classed = is_short || is_long;
    if (is_short) begin
      edge_class.kind = level ? rmcd_pkg::EV_SHORT_LOW : rmcd_pkg::EV_SHORT_HIGH;
    end else begin
      edge_class.kind = level ? rmcd_pkg::EV_LONG_LOW : rmcd_pkg::EV_LONG_HIGH;
    end
  end

endmodule

>>> rtl/rmcd_manchester.sv
module rmcd_manchester (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  restart,
  input  rmcd_pkg::edge_class_t edge_class,
  output rmcd_pkg::bit_out_t    bit_out
);

  rmcd_pkg::phase_t phase;
  rmcd_pkg::phase_t phase_next;
  rmcd_pkg::phase_t table_next;

  always_comb begin
    table_next = rmcd_pkg::phase_next(phase, edge_class.kind);
    phase_next = phase;
    bit_out    = '0;
    if (restart) begin
      phase_next = rmcd_pkg::PHASE_MID1;
    end else if (edge_class.classed) begin
      if (table_next == phase) begin
        // illegal event, resync on mid-one
        phase_next = rmcd_pkg::PHASE_MID1;
      end else begin
        phase_next = table_next;
        if (table_next == rmcd_pkg::PHASE_MID1) begin
          bit_out.valid = 1'b1;
          bit_out.value = 1'b1;
        end else if (table_next == rmcd_pkg::PHASE_MID0) begin
          bit_out.valid = 1'b1;
          bit_out.value = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= rmcd_pkg::PHASE_MID1;
    end else if (step) begin
      phase <= phase_next;
    end
  end

endmodule

>>> rtl/rmcd_frame.sv
module rmcd_frame (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           restart,
  input  rmcd_pkg::bit_out_t             bit_in,
  output logic                           found,
  output logic [rmcd_pkg::CardWidth-1:0] card_next
);

  logic [rmcd_pkg::FrameWidth-1:0] frame_bits;
  logic [rmcd_pkg::FrameWidth-1:0] frame_next;
  logic [rmcd_pkg::CardWidth-1:0]  card_value;
  logic [5:0]                      tag;
  logic                            valid_frame;

  always_comb begin
    frame_next = frame_bits;
    if (restart) begin
      frame_next = '0;
    end else if (bit_in.valid) begin
      frame_next = {frame_bits[rmcd_pkg::FrameWidth-2:0], bit_in.value};
    end
  end

  // oldest bit sits at the top of the word
  assign tag         = frame_next[50:45];
  assign valid_frame = (frame_next[63:53] == rmcd_pkg::Preamble) &&
                       (tag != rmcd_pkg::BadTagA) && (tag != rmcd_pkg::BadTagB);
  assign found       = !restart && bit_in.valid && valid_frame;
  assign card_next   = found ? {frame_next[25:18], frame_next[16:9], frame_next[7:0]}
                             : card_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits <= '0;
      card_value <= '0;
    end else if (step) begin
      frame_bits <= frame_next;
      card_value <= card_next;
    end
  end

endmodule

>>> rtl/rfid_manchester_card_decoder_unit.sv
// an input transfer lands in the input register, its result in the output register when
// the working stage advances; throughput: one edge per cycle unless the output stalls;
// the phase, frame and card update all close in the same cycle, and the input register
// advances whenever it is empty or the output register is empty or being taken
// reset (rst, synchronous, active high) clears both valid flags, sets the decoder to
// mid-one, clears the frame and the card number and loads the default window bounds
module rfid_manchester_card_decoder_unit (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [rmcd_pkg::CfgWidth-1:0]     cfg_data,
  // edge stream in
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rmcd_pkg::InDataWidth-1:0]  s_tdata,   // level [0], span_us [16:1], zero pad
  input  logic                              s_tuser,   // cmd [0]
  // result stream out
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rmcd_pkg::OutDataWidth-1:0] m_tdata,   // card_number [23:0]
  output logic                              m_tuser    // found [0]
);

  // window bounds
  logic [rmcd_pkg::CfgWidth-1:0] short_min;
  logic [rmcd_pkg::CfgWidth-1:0] short_max;
  logic [rmcd_pkg::CfgWidth-1:0] long_min;
  logic [rmcd_pkg::CfgWidth-1:0] long_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_min <= rmcd_pkg::ShortMinReset;
      short_max <= rmcd_pkg::ShortMaxReset;
      long_min  <= rmcd_pkg::LongMinReset;
      long_max  <= rmcd_pkg::LongMaxReset;
    end else if (cfg_we) begin
      case (rmcd_pkg::cfg_index_t'(cfg_index))
        rmcd_pkg::CFG_SHORT_MIN: short_min <= cfg_data;
        rmcd_pkg::CFG_SHORT_MAX: short_max <= cfg_data;
        rmcd_pkg::CFG_LONG_MIN:  long_min  <= cfg_data;
        rmcd_pkg::CFG_LONG_MAX:  long_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                           in_valid;
  logic                           in_cmd;
  logic                           in_level;
  logic [rmcd_pkg::SpanWidth-1:0] in_span;
  logic                           advance;
  logic                           step;

  // the working stage moves on when the output register is free or being drained
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd   <= s_tuser;
      in_level <= s_tdata[0];
      in_span  <= s_tdata[rmcd_pkg::SpanWidth:1];
    end
  end

  // working stage: classify, decode, shift and check
  rmcd_pkg::edge_class_t          edge_class;
  rmcd_pkg::bit_out_t             bit_out;
  logic                           restart;
  logic                           found;
  logic [rmcd_pkg::CardWidth-1:0] card_next;

  assign restart = (rmcd_pkg::cmd_t'(in_cmd) == rmcd_pkg::CMD_RESTART);

  rmcd_classify u_classify (
    .level      (in_level),
    .span_us    (in_span),
    .short_min  (short_min),
    .short_max  (short_max),
    .long_min   (long_min),
    .long_max   (long_max),
    .edge_class (edge_class)
  );

  rmcd_manchester u_manchester (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .restart    (restart),
    .edge_class (edge_class),
    .bit_out    (bit_out)
  );

  rmcd_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .restart   (restart),
    .bit_in    (bit_out),
    .found     (found),
    .card_next (card_next)
  );

  // output register, one result per edge
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tuser <= found;
      m_tdata <= card_next;
    end
  end

endmodule

>>> rtl/rmcd_checker.sv
module rmcd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [rmcd_pkg::OutDataWidth-1:0] m_tdata,
  input logic                              m_tuser
);

  logic [rmcd_pkg::CardWidth-1:0] last_card;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_card <= '0;
    end else if (m_tvalid && m_tready) begin
      last_card <= m_tdata[rmcd_pkg::CardWidth-1:0];
    end
  end

  // the card number only changes on a transfer that reports a found frame
  a_card_kept: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tuser) |-> (m_tdata[rmcd_pkg::CardWidth-1:0] == last_card))
    else $error("card number changed without a found frame");

  // an empty output stage never holds back the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output empty");

  // an edge taken while the output is empty, once past the input register, leaves a valid output
  a_input_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> ##1 m_tvalid)
    else $error("accepted edge produced no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind rfid_manchester_card_decoder_unit rmcd_checker u_rmcd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import rmcd_pkg::*;

  // one demodulated edge as queued for the sender, with an optional typed-in result
  typedef struct {
    logic                 found;
    logic [CardWidth-1:0] card;
  } card_result_t;

  typedef struct {
    cmd_t                 cmd;
    logic                 level;
    logic [SpanWidth-1:0] span;
    logic                 typed;
    card_result_t         want;
  } edge_item_t;

  // directed table row: typed = 1 means the result below is compared as written
  typedef struct packed {
    cmd_t                 cmd;
    logic                 level;
    logic [SpanWidth-1:0] span;
    logic                 typed;
    logic                 found;
    logic [CardWidth-1:0] card;
  } dir_row_t;

  localparam int NumDir = 25;
  localparam dir_row_t DirTable [NumDir] = '{
    '{CMD_RESTART, 1'b0, 16'd0,     1'b1, 1'b0, 24'd0},  // restart straight after reset
    '{CMD_FEED,    1'b0, 16'd0,     1'b1, 1'b0, 24'd0},  // shortest span, in no window
    '{CMD_FEED,    1'b1, 16'd65535, 1'b1, 1'b0, 24'd0},  // saturated span, in no window
    '{CMD_FEED,    1'b1, 16'd96,    1'b1, 1'b0, 24'd0},  // short lower bound is open
    '{CMD_FEED,    1'b0, 16'd224,   1'b1, 1'b0, 24'd0},  // short upper bound is open
    '{CMD_FEED,    1'b0, 16'd256,   1'b1, 1'b0, 24'd0},  // long lower bound is open
    '{CMD_FEED,    1'b1, 16'd384,   1'b1, 1'b0, 24'd0},  // long upper bound is open
    '{CMD_FEED,    1'b1, 16'd97,    1'b0, 1'b0, 24'd0},  // short-low at mid-one: illegal
    '{CMD_FEED,    1'b0, 16'd223,   1'b0, 1'b0, 24'd0},  // short-high: to start-of-one
    '{CMD_FEED,    1'b1, 16'd97,    1'b0, 1'b0, 24'd0},  // short-low: mid-one, bit 1
    '{CMD_FEED,    1'b0, 16'd257,   1'b0, 1'b0, 24'd0},  // long-high: mid-zero, bit 0
    '{CMD_FEED,    1'b1, 16'd383,   1'b0, 1'b0, 24'd0},  // long-low: mid-one, bit 1
    '{CMD_FEED,    1'b0, 16'd150,   1'b0, 1'b0, 24'd0},  // to start-of-one
    '{CMD_FEED,    1'b0, 16'd150,   1'b0, 1'b0, 24'd0},  // short-high at start-of-one
    '{CMD_FEED,    1'b0, 16'd150,   1'b0, 1'b0, 24'd0},
    '{CMD_FEED,    1'b0, 16'd300,   1'b0, 1'b0, 24'd0},  // long-high at start-of-one
    '{CMD_FEED,    1'b0, 16'd300,   1'b0, 1'b0, 24'd0},  // to mid-zero
    '{CMD_FEED,    1'b0, 16'd150,   1'b0, 1'b0, 24'd0},  // short-high at mid-zero
    '{CMD_FEED,    1'b0, 16'd300,   1'b0, 1'b0, 24'd0},
    '{CMD_FEED,    1'b1, 16'd150,   1'b0, 1'b0, 24'd0},  // short-low: start-of-zero
    '{CMD_FEED,    1'b1, 16'd300,   1'b0, 1'b0, 24'd0},  // long-low at start-of-zero
    '{CMD_FEED,    1'b0, 16'd300,   1'b0, 1'b0, 24'd0},
    '{CMD_FEED,    1'b1, 16'd150,   1'b0, 1'b0, 24'd0},
    '{CMD_FEED,    1'b0, 16'd150,   1'b0, 1'b0, 24'd0},  // short-high: mid-zero, bit 0
    '{CMD_RESTART, 1'b1, 16'd65535, 1'b1, 1'b0, 24'd0}   // restart keeps the card number
  };

  localparam int HoldCycles = 400;  // long receiver hold-off
  localparam int SettleCycles = 4;  // pipeline settle before register writes
  localparam int DrainCycles = 8;   // quiet tail after the last result

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [1:0]              cfg_index = CFG_SHORT_MIN;
  logic [CfgWidth-1:0]     cfg_data = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [InDataWidth-1:0]  s_tdata = '0;   // level [0], span_us [16:1], zero pad
  logic                    s_tuser = 1'b0;  // cmd [0]
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OutDataWidth-1:0] m_tdata;         // card_number [23:0]
  logic                    m_tuser;         // found [0]

  rfid_manchester_card_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop in case the handshake hangs
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // window bounds as the block should hold them
  logic [CfgWidth-1:0] win_short_min = ShortMinReset;
  logic [CfgWidth-1:0] win_short_max = ShortMaxReset;
  logic [CfgWidth-1:0] win_long_min  = LongMinReset;
  logic [CfgWidth-1:0] win_long_max  = LongMaxReset;

  // decoder state as the block should hold it
  logic [FrameWidth-1:0] frame_bits_q;
  phase_t                phase_q;
  logic [CardWidth-1:0]  card_q;

  edge_item_t   edge_queue[$];     // edges waiting for the sender
  card_result_t pending_cards[$];  // results owed by the block, oldest first
  int           err_cnt = 0;
  int           queued_cnt = 0;
  bit           in_taken = 1'b0;   // input transfer at the last rising edge
  bit           enc_mid1 = 1'b1;   // encoder's view of the decoder phase
  bit           hold_req = 1'b0;
  card_result_t cur_want = '{1'b0, '0};
  logic         cur_typed = 1'b0;

  // short window is tried first, so overlaps resolve to short
  function automatic edge_class_t classify_edge(input logic level, input logic [15:0] span);
    edge_class_t cls;
    cls.classed = 1'b1;
    if (span > win_short_min && span < win_short_max) begin
      cls.kind = level ? EV_SHORT_LOW : EV_SHORT_HIGH;
    end else if (span > win_long_min && span < win_long_max) begin
      cls.kind = level ? EV_LONG_LOW : EV_LONG_HIGH;
    end else begin
      cls.classed = 1'b0;
      cls.kind = EV_SHORT_LOW;
    end
    return cls;
  endfunction

  function automatic phase_t next_phase(input phase_t cur, input event_t ev);
    phase_t nxt;
    case (cur)
      PHASE_START1: nxt = (ev == EV_SHORT_LOW) ? PHASE_MID1 : PHASE_START1;
      PHASE_MID1: begin
        case (ev)
          EV_SHORT_HIGH: nxt = PHASE_START1;
          EV_LONG_HIGH:  nxt = PHASE_MID0;
          default:       nxt = PHASE_MID1;
        endcase
      end
      PHASE_MID0: begin
        case (ev)
          EV_SHORT_LOW: nxt = PHASE_START0;
          EV_LONG_LOW:  nxt = PHASE_MID1;
          default:      nxt = PHASE_MID0;
        endcase
      end
      default: nxt = (ev == EV_SHORT_HIGH) ? PHASE_MID0 : PHASE_START0;
    endcase
    return nxt;
  endfunction

  // advances the decoder by one edge and gives the result the block must show
  task automatic decode_edge(input cmd_t cmd, input logic level, input logic [15:0] span,
                             output card_result_t res);
    edge_class_t cls;
    phase_t      nxt;
    logic        emit;
    logic        bit_val;
    res.found = 1'b0;
    emit = 1'b0;
    bit_val = 1'b0;
    if (cmd == CMD_RESTART) begin
      frame_bits_q = '0;
      phase_q = PHASE_MID1;
    end else begin
      cls = classify_edge(level, span);
      if (cls.classed) begin
        nxt = next_phase(phase_q, cls.kind);
        // a move that stays put is illegal and falls back to mid-one silently
        if (nxt == phase_q) begin
          nxt = PHASE_MID1;
        end else if (nxt == PHASE_MID1) begin
          emit = 1'b1;
          bit_val = 1'b1;
        end else if (nxt == PHASE_MID0) begin
          emit = 1'b1;
        end
        phase_q = nxt;
        if (emit) begin
          frame_bits_q = {frame_bits_q[FrameWidth-2:0], bit_val};
          // frame index i sits at bit 63-i
          if (frame_bits_q[63:53] == Preamble &&
              frame_bits_q[50:45] != BadTagA && frame_bits_q[50:45] != BadTagB) begin
            card_q = {frame_bits_q[25:18], frame_bits_q[16:9], frame_bits_q[7:0]};
            res.found = 1'b1;
          end
        end
      end
    end
    res.card = card_q;
  endtask

  // checks results first, then books the input transfer of the same edge
  always @(posedge clk) begin : monitor
    card_result_t want;
    if (rst) begin
      frame_bits_q = '0;
      phase_q = PHASE_MID1;
      card_q = '0;
      in_taken = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_cards.size() == 0) begin
          if (err_cnt < 10) $display("result with nothing pending: found=%0d card=%06h",
                                     m_tuser, m_tdata);
          err_cnt++;
        end else begin
          want = pending_cards.pop_front();
          if (m_tuser !== want.found || m_tdata[CardWidth-1:0] !== want.card) begin
            if (err_cnt < 10)
              $display("mismatch: expected found=%0d card=%06h, got found=%0d card=%06h",
                       want.found, want.card, m_tuser, m_tdata);
            err_cnt++;
          end
        end
      end
      in_taken = s_tvalid && s_tready;
      if (in_taken) begin
        decode_edge(cmd_t'(s_tuser), s_tdata[0], s_tdata[16:1], want);
        if (cur_typed) want = cur_want;
        pending_cards.push_back(want);
      end
    end
  end

  // sender: bursts of random length, random gaps, sometimes back to back
  int burst_left = 8;
  int gap_left = 0;

  always @(negedge clk) begin : sender
    edge_item_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (edge_queue.size() > 0) begin
        item = edge_queue.pop_front();
        s_tdata <= {{(InDataWidth-SpanWidth-1){1'b0}}, item.span, item.level};
        s_tuser <= item.cmd;
        cur_typed <= item.typed;
        cur_want <= item.want;
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(24, 1);
          gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern redrawn periodically, plus one long hold-off on request
  int rx_cyc = 0;
  int rx_mode = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    rx_cyc++;
    if (rx_cyc % 50 == 0) rx_mode = $urandom_range(3, 0);
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles - 1;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(3, 0) != 0);
        2:       m_tready <= 1'($urandom_range(1, 0));
        default: m_tready <= (rx_cyc[1:0] == 2'b00);
      endcase
    end
  end

  task automatic push_edge(input cmd_t cmd, input logic level, input logic [15:0] span);
    edge_item_t item;
    item.cmd = cmd;
    item.level = level;
    item.span = span;
    item.typed = 1'b0;
    item.want = '{1'b0, '0};
    edge_queue.push_back(item);
    queued_cnt++;
    if (cmd == CMD_RESTART) enc_mid1 = 1'b1;
  endtask

  // a span in the wanted window, drawn up to 16 times until the block classes it that way
  function automatic logic [15:0] pick_span(input bit want_long, input logic level);
    int          lo;
    int          hi;
    logic [15:0] span;
    edge_class_t cls;
    lo = int'(want_long ? win_long_min : win_short_min);
    hi = int'(want_long ? win_long_max : win_short_max);
    span = 16'(lo);
    if (hi > lo + 1) begin
      for (int k = 0; k < 16; k++) begin
        span = 16'($urandom_range(hi - 1, lo + 1));
        cls = classify_edge(level, span);
        if (cls.classed && ((cls.kind == EV_LONG_LOW || cls.kind == EV_LONG_HIGH) == want_long))
          break;
      end
    end
    return span;
  endfunction

  task automatic push_event(input bit want_long, input logic level);
    // now and then an ignored edge or a stray in-window edge slips in
    if ($urandom_range(39, 0) == 0) push_edge(CMD_FEED, 1'($urandom_range(1, 0)), 16'd0);
    if ($urandom_range(149, 0) == 0)
      push_edge(CMD_FEED, 1'($urandom_range(1, 0)), pick_span(1'($urandom_range(1, 0)), 1'b0));
    push_edge(CMD_FEED, level, pick_span(want_long, level));
  endtask

  // manchester encoding from the two mid phases
  task automatic push_bit(input logic b);
    if (enc_mid1) begin
      if (b) begin
        push_event(1'b0, 1'b0);
        push_event(1'b0, 1'b1);
      end else begin
        push_event(1'b1, 1'b0);
        enc_mid1 = 1'b0;
      end
    end else begin
      if (!b) begin
        push_event(1'b0, 1'b1);
        push_event(1'b0, 1'b0);
      end else begin
        push_event(1'b1, 1'b1);
        enc_mid1 = 1'b1;
      end
    end
  endtask

  task automatic push_frame();
    logic [FrameWidth-1:0] f;
    int                    r;
    f = {$urandom, $urandom};
    f[63:53] = Preamble;
    r = $urandom_range(5, 0);
    if (r == 0) f[50:45] = BadTagA;
    else if (r == 1) f[50:45] = BadTagB;
    // occasionally a broken preamble
    if ($urandom_range(7, 0) == 0) f[6'($urandom_range(63, 53))] ^= 1'b1;
    if ($urandom_range(7, 0) != 0)
      push_edge(CMD_RESTART, 1'($urandom_range(1, 0)), 16'($urandom));
    for (int i = FrameWidth - 1; i >= 0; i--) push_bit(f[i]);
    r = $urandom_range(2, 0);
    for (int i = 0; i < r; i++) push_bit(1'($urandom_range(1, 0)));
  endtask

  task automatic push_noise();
    int n;
    int r;
    n = $urandom_range(20, 5);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(15, 0);
      if (r == 0) push_edge(CMD_RESTART, 1'($urandom_range(1, 0)), 16'($urandom));
      else if (r < 8) push_edge(CMD_FEED, 1'($urandom_range(1, 0)), 16'($urandom));
      else push_edge(CMD_FEED, 1'($urandom_range(1, 0)),
                     pick_span(1'($urandom_range(1, 0)), 1'b0));
    end
  endtask

  // everything sent and answered, then a pause of SettleCycles for the pipeline to settle
  task automatic wait_idle();
    do @(posedge clk);
    while (edge_queue.size() != 0 || s_tvalid || pending_cards.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CfgWidth-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SHORT_MIN: win_short_min = val;
      CFG_SHORT_MAX: win_short_max = val;
      CFG_LONG_MIN:  win_long_min = val;
      default:       win_long_max = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_windows(input int smin, input int smax, input int lmin, input int lmax);
    write_reg(CFG_SHORT_MIN, 16'(smin));
    write_reg(CFG_SHORT_MAX, 16'(smax));
    write_reg(CFG_LONG_MIN, 16'(lmin));
    write_reg(CFG_LONG_MAX, 16'(lmax));
  endtask

  // one setting of the windows: mostly well-formed frames where they can be encoded
  task automatic run_phase(input int budget, input bit frames_ok, input bit long_hold);
    int start;
    start = queued_cnt;
    while (queued_cnt - start < budget) begin
      if (frames_ok && $urandom_range(9, 0) < 7) push_frame();
      else push_noise();
    end
    // sender keeps offering while the receiver sits still
    if (long_hold) hold_req = 1'b1;
    wait_idle();
  endtask

  initial begin : main
    int smin;
    int smax;
    int lmin;
    edge_item_t item;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < NumDir; i++) begin
      item.cmd = DirTable[i].cmd;
      item.level = DirTable[i].level;
      item.span = DirTable[i].span;
      item.typed = DirTable[i].typed;
      item.want.found = DirTable[i].found;
      item.want.card = DirTable[i].card;
      edge_queue.push_back(item);
    end
    enc_mid1 = 1'b1;
    wait_idle();

    // reset windows
    run_phase(160, 1'b1, 1'b0);

    // random disjoint windows, with the long receiver hold-off
    smin = $urandom_range(200, 20);
    smax = smin + $urandom_range(200, 10);
    lmin = smax + $urandom_range(50, 0);
    set_windows(smin, smax, lmin, lmin + $urandom_range(300, 10));
    run_phase(160, 1'b1, 1'b1);

    // overlapping windows: the short test wins
    set_windows(100, 400, 200, 600);
    run_phase(130, 1'b1, 1'b0);

    // everything but the two extreme spans short, long window inverted
    set_windows(0, 65535, 65535, 0);
    run_phase(60, 1'b0, 1'b0);

    // all bounds zero: nothing is ever classed
    set_windows(0, 0, 0, 0);
    run_phase(40, 1'b0, 1'b0);

    // short window empty at the top, everything but the two extreme spans long
    set_windows(65535, 65535, 0, 65535);
    run_phase(60, 1'b0, 1'b0);

    // high windows, long one reaching the saturation value
    set_windows(30000, 40000, 40000, 65535);
    run_phase(90, 1'b1, 1'b0);

    // back to the reset values
    set_windows(int'(ShortMinReset), int'(ShortMaxReset), int'(LongMinReset),
                int'(LongMaxReset));
    run_phase(60, 1'b1, 1'b0);

    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0 && pending_cards.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rmcd_pkg.sv
rtl/rmcd_classify.sv
rtl/rmcd_manchester.sv
rtl/rmcd_frame.sv
rtl/rfid_manchester_card_decoder_unit.sv
rtl/rmcd_checker.sv
bench/tb.sv
